@@ rtl/fcdos_pkg.sv @@
`default_nettype none

package fcdos_pkg;

    localparam int TICK_PERIOD_US = 4;
    localparam int CHANNEL_COUNT  = 4;
    localparam int COUNTER_BITS   = 16;

    localparam int KIND_W   = 2;
    localparam int CH_W     = 2;
    localparam int DELAY_W  = 32;
    localparam int MAXD_W   = 18;
    localparam int OUT_CH_W = 4;
    localparam int OUT_CNT_W = 16;

    localparam logic [MAXD_W-1:0] MAX_DELAY_RESET = MAXD_W'(200000);

    // width reserved for the quotient of the clamped delay plus one: one bit more than the delay
    localparam int TICKS_W = MAXD_W + 1;
    localparam int EXT_W   = (COUNTER_BITS + 1 > TICKS_W) ? COUNTER_BITS + 1 : TICKS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_ARM    = 2'd1,
        KIND_DISARM = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

endpackage

`default_nettype wire

@@ rtl/four_channel_delayed_output_scheduler_core.sv @@
`default_nettype none

// Four one-shot output channels timed by a shared free-running tick counter.
// Each item is a timer tick, an arm (delay in microseconds, clamped to the
// maximum delay register and converted to ticks) or a disarm of one channel, and each
// item yields exactly one result: the channels that fired on it, all pin
// levels, the armed channels and the counter value after it. The block takes
// one item per clock unless o_in_stall is high; an item is registered on entry
// and its result is registered when the item is processed, which waits while
// the held result is stalled. The single register-to-register step holds the tick compare
// for all channels and the delay-to-target add. i_cfg_we writes the maximum
// delay and is meant for use while no item is in flight.
module four_channel_delayed_output_scheduler_core
    import fcdos_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_we,
    input  wire logic [MAXD_W-1:0]    i_cfg_data,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [CH_W-1:0]      i_channel,
    input  wire logic                 i_action_level,
    input  wire logic [DELAY_W-1:0]   i_req_delay,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [OUT_CH_W-1:0]       o_fired_mask,
    output logic [OUT_CH_W-1:0]       o_pin_levels,
    output logic [OUT_CH_W-1:0]       o_armed_mask,
    output logic [OUT_CNT_W-1:0]      o_tick_count
);

    // configuration
    logic [MAXD_W-1:0] r_max_delay;

    // input stage
    logic               r_s1_valid;
    logic [KIND_W-1:0]  r_s1_kind;
    logic [CH_W-1:0]    r_s1_ch;
    logic               r_s1_level;
    logic [DELAY_W-1:0] r_s1_delay;

    // channel state
    logic [COUNTER_BITS-1:0] r_cnt;
    logic [COUNTER_BITS-1:0] r_tgt [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] r_wait;
    logic [CHANNEL_COUNT-1:0] r_armed;
    logic [CHANNEL_COUNT-1:0] r_pend;
    logic [CHANNEL_COUNT-1:0] r_pin;

    logic [COUNTER_BITS-1:0] n_cnt;
    logic [CHANNEL_COUNT-1:0] n_wait;
    logic [CHANNEL_COUNT-1:0] n_armed;
    logic [CHANNEL_COUNT-1:0] n_pin;
    logic [CHANNEL_COUNT-1:0] n_fired;

    // result register
    logic                    r_out_valid;
    logic [CHANNEL_COUNT-1:0] r_fired;
    logic [CHANNEL_COUNT-1:0] r_res_pin;
    logic [CHANNEL_COUNT-1:0] r_res_armed;
    logic [COUNTER_BITS-1:0] r_res_cnt;

    logic out_free;
    logic proc;
    logic accept;
    logic is_tick;
    logic is_arm;
    logic is_disarm;
    logic ch_ok;

    logic [MAXD_W-1:0]       d_clamp;
    logic [EXT_W-1:0]        ticks;
    logic [EXT_W-1:0]        ticks_cap;
    logic [EXT_W-1:0]        sum;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic                    wrap;
    logic [COUNTER_BITS-1:0] arm_tgt;
    logic                    arm_wait;

    localparam logic [EXT_W-1:0] CNT_MAX_EXT =
        {{(EXT_W-COUNTER_BITS){1'b0}}, {COUNTER_BITS{1'b1}}};

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_tick   = (r_s1_kind == KIND_TICK);
    assign is_arm    = (r_s1_kind == KIND_ARM);
    assign is_disarm = (r_s1_kind == KIND_DISARM);
    assign ch_ok     = (32'(r_s1_ch) < 32'(CHANNEL_COUNT));

    // delay to target
    always_comb begin
        if (r_s1_delay > DELAY_W'(r_max_delay)) begin
            d_clamp = r_max_delay;
        end else begin
            d_clamp = r_s1_delay[MAXD_W-1:0];
        end
        ticks = EXT_W'(d_clamp) / EXT_W'(TICK_PERIOD_US) + EXT_W'(1);
        ticks_cap = (ticks > CNT_MAX_EXT) ? CNT_MAX_EXT : ticks;
        sum = EXT_W'(r_cnt) + ticks_cap;
        arm_tgt  = sum[COUNTER_BITS-1:0];
        arm_wait = sum[COUNTER_BITS];
    end

    assign cnt_inc = r_cnt + COUNTER_BITS'(1);
    assign wrap    = (cnt_inc == '0);

    always_comb begin
        n_cnt   = r_cnt;
        n_wait  = r_wait;
        n_armed = r_armed;
        n_pin   = r_pin;
        n_fired = '0;
        if (is_tick) begin
            n_cnt = cnt_inc;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                // wait flags clear on the wrap before the compare
                if (wrap) begin
                    n_wait[c] = 1'b0;
                end
                if (r_armed[c] && !n_wait[c] && r_tgt[c] == cnt_inc) begin
                    n_pin[c]   = r_pend[c];
                    n_armed[c] = 1'b0;
                    n_fired[c] = 1'b1;
                end
            end
        end else if (is_arm && ch_ok) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                if (32'(r_s1_ch) == c) begin
                    n_wait[c]  = arm_wait;
                    n_armed[c] = 1'b1;
                end
            end
        end else if (is_disarm && ch_ok) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                if (32'(r_s1_ch) == c) begin
                    n_wait[c]  = 1'b0;
                    n_armed[c] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delay <= MAX_DELAY_RESET;
        end else if (i_cfg_we) begin
            r_max_delay <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (proc) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= i_kind;
            r_s1_ch    <= i_channel;
            r_s1_level <= i_action_level;
            r_s1_delay <= i_req_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wait  <= '0;
            r_armed <= '0;
            r_pin   <= '0;
        end else if (proc) begin
            r_cnt   <= n_cnt;
            r_wait  <= n_wait;
            r_armed <= n_armed;
            r_pin   <= n_pin;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (proc && is_arm && ch_ok && 32'(r_s1_ch) == c) begin
                r_tgt[c]  <= arm_tgt;
                r_pend[c] <= r_s1_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_fired     <= n_fired;
            r_res_pin   <= n_pin;
            r_res_armed <= n_armed;
            r_res_cnt   <= n_cnt;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_fired_mask = '0;
        o_pin_levels = '0;
        o_armed_mask = '0;
        for (int c = 0; c < OUT_CH_W; c++) begin
            if (c < CHANNEL_COUNT) begin
                o_fired_mask[c] = r_fired[c];
                o_pin_levels[c] = r_res_pin[c];
                o_armed_mask[c] = r_res_armed[c];
            end
        end
    end

    logic [EXT_W+OUT_CNT_W-1:0] cnt_ext;
    assign cnt_ext      = (EXT_W+OUT_CNT_W)'(r_res_cnt);
    assign o_tick_count = cnt_ext[OUT_CNT_W-1:0];

    // only tick items can fire a channel
    a_fire_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && !is_tick |=> r_fired == '0)
        else $error("channel fired on a non-tick item");

    // a channel fires only if it was armed
    a_fire_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> (r_fired & ~$past(r_armed)) == '0)
        else $error("unarmed channel fired");

    // a fired channel is disarmed in the same result
    a_fired_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_fired & r_res_armed) == '0)
        else $error("fired channel still armed");

    // the counter moves only on tick items, and then by one
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && !is_tick |=> r_cnt == $past(r_cnt))
        else $error("counter moved on a non-tick item");

endmodule

`default_nettype wire
